// File: hw/rtl/consistent_hash_ring_macros.svh
// assertion macros for the consistent hash ring checker
// no dependencies; included by files that hold concurrent assertions
`ifndef CONSISTENT_HASH_RING_MACROS_SVH
`define CONSISTENT_HASH_RING_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("consistent_hash_ring: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CHR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("consistent_hash_ring: assertion failed");

`endif

// File: hw/rtl/chr_pkg.sv
// shared types and constants for the consistent hash ring
// no dependencies; used by chr_cell, consistent_hash_ring and chr_checker
package chr_pkg;

  localparam int N_CELLS = 64;
  localparam int HASH_W  = 32;
  localparam int ID_W    = 16;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ERASE  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [HASH_W-1:0] item_hash;
    logic [15:0]       node_id;
  } chr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_node;
  } chr_out_t;

  // one ring entry as seen by neighbor cells
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [ID_W-1:0]   id;
  } chr_entry_t;

  // registered compare flags of one cell
  typedef struct packed {
    logic ge;
    logic eq;
  } chr_flag_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cap;
    logic ins;
    logic del;
  } chr_cmd_t;

endpackage

// File: hw/rtl/chr_cell.sv
// one ring cell: holds an entry, compares it to the key, shifts with neighbors
// depends on chr_pkg
module chr_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chr_pkg::chr_cmd_t            cmd,
  input  logic [chr_pkg::HASH_W-1:0]   key,
  input  logic [chr_pkg::ID_W-1:0]     key_id,
  input  chr_pkg::chr_entry_t          left_ent,
  input  chr_pkg::chr_flag_t           left_flag,
  input  chr_pkg::chr_entry_t          right_ent,
  output chr_pkg::chr_entry_t          ent,
  output chr_pkg::chr_flag_t           flag
);
  import chr_pkg::*;

  logic              valid_r, valid_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  chr_flag_t         flag_r, flag_nxt;
  logic              at_or_after;
  logic              left_at_or_after;

  assign ent  = '{valid: valid_r, hash: hash_r, id: id_r};
  assign flag = flag_r;

  // position test: this slot lies at or beyond the sorted insert point
  assign at_or_after      = flag_r.ge || !valid_r;
  assign left_at_or_after = left_flag.ge || !left_ent.valid;

  // compare, then shift right on insert or left on erase
  always_comb begin
    valid_nxt = valid_r;
    hash_nxt  = hash_r;
    id_nxt    = id_r;
    flag_nxt  = flag_r;
    if (cmd.cap) begin
      flag_nxt.ge = valid_r && (hash_r >= key);
      flag_nxt.eq = valid_r && (hash_r == key);
    end
    if (cmd.ins) begin
      if (left_at_or_after) begin
        valid_nxt = left_ent.valid;
        hash_nxt  = left_ent.hash;
        id_nxt    = left_ent.id;
      end else if (at_or_after) begin
        valid_nxt = 1'b1;
        hash_nxt  = key;
        id_nxt    = key_id;
      end
    end else if (cmd.del) begin
      if (flag_r.ge) begin
        valid_nxt = right_ent.valid;
        hash_nxt  = right_ent.hash;
        id_nxt    = right_ent.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload and flags need no reset
  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    id_r   <= id_nxt;
    flag_r <= flag_nxt;
  end

endmodule

// File: hw/rtl/consistent_hash_ring.sv
// top level of the consistent hash ring: sequencer, row of cells, result select
// depends on chr_pkg and chr_cell
//
// Usage
//   Input channel: drive in_item (op, item_hash, node_id) and raise start;
//   the transaction is taken at a rising edge where start is high and busy
//   is low. Add inserts a node in hash order, erase removes the entry with a
//   matching hash, lookup returns the first node whose hash is at least the
//   key, wrapping to the lowest node.
//   Result channel: out_valid strobes for one cycle with out_item (status,
//   result_node). Every transaction gives exactly one result, and the
//   receiver cannot stall it.
//   Timing: a transaction taken at a rising edge has its compare flags
//   registered in the compare state; in the update state the cells shift
//   and the result is registered, so out_valid is high in the cycle after
//   the update. busy is high from the taking edge until the update, so the
//   block cannot take a new transaction before the last one has completed.
//   The spacing is set by the compare stage in each cell followed by the
//   ring-wide select and shift.
//   Reset: rst_n (synchronous, active low) clears every cell's valid bit,
//   which empties the ring at once; no clearing pass follows.
module consistent_hash_ring (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  chr_pkg::chr_in_t  in_item,
  output logic              busy,
  output logic              out_valid,
  output chr_pkg::chr_out_t out_item
);
  import chr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t            state_r, state_nxt;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  chr_out_t          out_item_r, out_item_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [HASH_W-1:0] key_r, key_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  chr_cmd_t          cmd;
  chr_entry_t        ent_a  [N_CELLS];
  chr_flag_t         flag_a [N_CELLS];
  logic [N_CELLS-1:0] ge_v, eq_v, first_v;
  logic              any_ge, found, ring_full, ring_empty;
  logic [ID_W-1:0]   sel_id, hit_id;

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // row of cells, each wired to its two neighbors
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    chr_entry_t left_ent, right_ent;
    chr_flag_t  left_flag;
    if (i == 0) begin : g_first
      assign left_ent  = '{valid: 1'b1, hash: '0, id: '0};
      assign left_flag = '{ge: 1'b0, eq: 1'b0};
    end else begin : g_mid
      assign left_ent  = ent_a[i-1];
      assign left_flag = flag_a[i-1];
    end
    if (i == N_CELLS - 1) begin : g_last
      assign right_ent = '{valid: 1'b0, hash: '0, id: '0};
    end else begin : g_inner
      assign right_ent = ent_a[i+1];
    end
    chr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .key       (key_r),
      .key_id    (id_r),
      .left_ent  (left_ent),
      .left_flag (left_flag),
      .right_ent (right_ent),
      .ent       (ent_a[i]),
      .flag      (flag_a[i])
    );
    assign ge_v[i]    = flag_a[i].ge;
    assign eq_v[i]    = flag_a[i].eq;
    assign first_v[i] = flag_a[i].ge && !left_flag.ge;
  end

  // ring-wide summary of the registered compare flags
  assign any_ge     = |ge_v;
  assign found      = |eq_v;
  assign ring_full  = ent_a[N_CELLS-1].valid;
  assign ring_empty = !ent_a[0].valid;

  // id of the first entry at or above the key (one-hot and-or select)
  always_comb begin
    hit_id = '0;
    for (int k = 0; k < N_CELLS; k++) begin
      hit_id = hit_id | (ent_a[k].id & {ID_W{first_v[k]}});
    end
  end
  assign sel_id = any_ge ? hit_id : ent_a[0].id;

  // cell commands: capture in the compare state, insert or erase in the update state
  always_comb begin
    cmd     = '0;
    cmd.cap = (state_r == S_CMP);
    if (state_r == S_UPD) begin
      cmd.ins = (op_r == OP_ADD) && !found && !ring_full;
      cmd.del = (op_r == OP_ERASE) && found;
    end
  end

  // sequencer next state and result
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    id_nxt        = id_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.op;
          key_nxt   = in_item.item_hash;
          id_nxt    = in_item.node_id[ID_W-1:0];
          busy_nxt  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        out_item_nxt.status      = ST_OK;
        out_item_nxt.result_node = '0;
        case (op_r)
          OP_ADD: begin
            if (found) begin
              out_item_nxt.status = ST_DUP;
            end else if (ring_full) begin
              out_item_nxt.status = ST_FULL;
            end
          end
          OP_ERASE: begin
            if (!found) begin
              out_item_nxt.status = ST_MISSING;
            end
          end
          OP_LOOKUP: begin
            if (ring_empty) begin
              out_item_nxt.status = ST_EMPTY;
            end else begin
              out_item_nxt.result_node = 16'(sel_id);
            end
          end
          default: begin
            out_item_nxt.status = ST_OK;
          end
        endcase
        out_valid_nxt = 1'b1;
        busy_nxt      = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        busy_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // transaction payload holds
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    id_r       <= id_nxt;
  end

endmodule

// File: hw/rtl/chr_checker.sv
// port-level checker for the consistent hash ring, bound to the top level
// depends on chr_pkg and consistent_hash_ring_macros.svh
`include "consistent_hash_ring_macros.svh"

module chr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input chr_pkg::chr_out_t out_item
);
  import chr_pkg::*;

  logic accept;
  logic nz_status;
  assign accept    = start && !busy;
  assign nz_status = out_valid && (out_item.status != ST_OK);

  // an accepted transaction holds the block busy in the next cycle
  `CHR_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  // every accepted transaction gives its result once the compare and update states have passed
  `CHR_ASSERT_IMP(a_result_due, clk, rst_n, accept, ##3 out_valid)
  // a result strobe never lasts more than one cycle
  `CHR_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // a failed status never carries a node id
  `CHR_ASSERT_IMP(a_node_zero, clk, rst_n, nz_status, out_item.result_node == '0)
  // status stays within the defined codes
  `CHR_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_item.status <= ST_EMPTY)

endmodule

bind consistent_hash_ring chr_checker u_chr_checker (.*);

// File: tb/consistent_hash_ring_tb.sv
// self-checking testbench for consistent_hash_ring: directed, full-ring and random ops
// depends on chr_pkg and the consistent_hash_ring rtl; a sorted-ring predictor checks
// every result transaction in order against the block's output
module consistent_hash_ring_tb;
  import chr_pkg::*;

  // spare op code with no defined operation
  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  chr_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  chr_out_t out_item;

  consistent_hash_ring u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted ring contents, sorted by hash
  logic [HASH_W-1:0] ring_hash [N_CELLS];
  logic [ID_W-1:0]   ring_id   [N_CELLS];
  int                ring_count = 0;

  chr_out_t          pending_results[$];
  chr_out_t          want;
  logic [31:0]       hash_pool [128];
  int                error_count = 0;
  int                cycle_count = 0;
  int                op_seen [4] = '{default: 0};
  int                status_seen [5] = '{default: 0};
  int                wrap_lookups = 0;
  bit                burst_mode = 1'b0;

  // apply one transaction to the predicted ring and return its result
  function automatic chr_out_t ring_apply(input chr_in_t item);
    chr_out_t res;
    int       pos;
    int       i;
    res = '0;
    pos = 0;
    while (pos < ring_count && ring_hash[pos] < item.item_hash) pos++;
    case (item.op)
      OP_ADD: begin
        if (pos < ring_count && ring_hash[pos] == item.item_hash) begin
          res.status = ST_DUP;
        end else if (ring_count == N_CELLS) begin
          res.status = ST_FULL;
        end else begin
          for (i = ring_count; i > pos; i--) begin
            ring_hash[i] = ring_hash[i-1];
            ring_id[i]   = ring_id[i-1];
          end
          ring_hash[pos] = item.item_hash;
          ring_id[pos]   = item.node_id;
          ring_count++;
        end
      end
      OP_ERASE: begin
        if (pos < ring_count && ring_hash[pos] == item.item_hash) begin
          for (i = pos; i + 1 < ring_count; i++) begin
            ring_hash[i] = ring_hash[i+1];
            ring_id[i]   = ring_id[i+1];
          end
          ring_count--;
        end else begin
          res.status = ST_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // key above every hash wraps to the lowest entry
          if (pos >= ring_count) begin
            pos = 0;
            wrap_lookups++;
          end
          res.result_node = ring_id[pos];
        end
      end
      default: res = '0;
    endcase
    op_seen[item.op]++;
    status_seen[res.status]++;
    return res;
  endfunction

  // result checker and prediction at each accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual status %0d node %h",
                   $time, out_item.status, out_item.result_node);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_item.status);
            error_count++;
          end
          if (out_item.result_node !== want.result_node) begin
            $display("%0t: result_node mismatch, expected %h actual %h",
                     $time, want.result_node, out_item.result_node);
            error_count++;
          end
        end
      end
      if (start && !busy) pending_results.push_back(ring_apply(in_item));
    end
  end

  // cycle counter and timeout
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("consistent_hash_ring regression: fail");
    $finish;
  end

  // send one transaction after a random gap (none in burst mode) and wait until it is taken
  task automatic send_op(input logic [1:0] op, input logic [31:0] h, input logic [15:0] id);
    chr_in_t item;
    int      gap;
    item.op         = op;
    item.item_hash  = h;
    item.node_id    = id;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
  endtask

  // hold off the sender until every result has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // edges of the fields and every special case but a full ring on a small ring
  task automatic test_directed();
    send_op(OP_LOOKUP, 32'h0000_0005, 16'h0001);
    send_op(OP_ERASE,  32'h0000_0000, 16'h0000);
    send_op(OP_SPARE,  32'hFFFF_FFFF, 16'hFFFF);
    send_op(OP_ADD,    32'h0000_0000, 16'h0000);
    send_op(OP_ADD,    32'hFFFF_FFFF, 16'hFFFF);
    send_op(OP_ADD,    32'h8000_0000, 16'h1234);
    send_op(OP_ADD,    32'h8000_0000, 16'h4321);
    send_op(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    send_op(OP_LOOKUP, 32'h0000_0001, 16'hFFFF);
    send_op(OP_LOOKUP, 32'h8000_0000, 16'h0000);
    send_op(OP_LOOKUP, 32'h8000_0001, 16'h0000);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    send_op(OP_ERASE,  32'h7FFF_FFFF, 16'h0000);
    send_op(OP_ERASE,  32'hFFFF_FFFF, 16'h0000);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    send_op(OP_LOOKUP, 32'h9000_0000, 16'h0000);
    send_op(OP_ADD,    32'h5555_5555, 16'hAAAA);
    send_op(OP_ADD,    32'hAAAA_AAAA, 16'h5555);
    send_op(OP_LOOKUP, 32'h6000_0000, 16'h0000);
    send_op(OP_SPARE,  32'h0000_0000, 16'h0000);
    send_op(OP_ERASE,  32'h0000_0000, 16'h0000);
    send_op(OP_ERASE,  32'h5555_5555, 16'h0000);
    send_op(OP_ERASE,  32'h8000_0000, 16'h0000);
    send_op(OP_ERASE,  32'hAAAA_AAAA, 16'h0000);
    send_op(OP_LOOKUP, 32'h0000_0000, 16'h0000);
  endtask

  // fill the ring to capacity, hit the full and duplicate cases, then empty it
  task automatic test_full_ring();
    int          i;
    logic [31:0] h;
    for (i = 0; i < N_CELLS; i++) begin
      // low bits carry the slot so every hash is distinct
      h = {26'($urandom_range(0, 32'h03FF_FFFF)), i[5:0]};
      send_op(OP_ADD, h[31:0], 16'($urandom));
    end
    wait_for_drain();
    send_op(OP_ADD, ring_hash[$urandom_range(0, N_CELLS - 1)], 16'($urandom));
    send_op(OP_ADD, $urandom, 16'($urandom));
    send_op(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    for (i = 0; i < 12; i++) send_op(OP_LOOKUP, $urandom, 16'($urandom));
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    wait_for_drain();
    while (ring_count > 0) begin
      send_op(OP_ERASE, ring_hash[$urandom_range(0, ring_count - 1)], 16'($urandom));
      wait_for_drain();
    end
  endtask

  // random mix in phases that alternately grow and shrink the ring
  task automatic test_random_ops();
    int          phase;
    int          n;
    int          pick;
    int          add_w;
    int          erase_w;
    int          idx;
    logic [31:0] h;
    hash_pool[0] = 32'h0000_0000;
    hash_pool[1] = 32'hFFFF_FFFF;
    for (n = 2; n < 128; n++) hash_pool[n] = $urandom;
    for (phase = 0; phase < 7; phase++) begin
      burst_mode = (phase % 3 == 1);
      add_w   = (phase % 2 == 0) ? 60 : 20;
      erase_w = (phase % 2 == 0) ? 10 : 50;
      for (n = 0; n < 220; n++) begin
        pick = $urandom_range(0, 99);
        idx  = (ring_count > 0) ? $urandom_range(0, ring_count - 1) : 0;
        if (pick < add_w) begin
          h = ($urandom_range(0, 9) < 7) ? hash_pool[$urandom_range(0, 127)] : $urandom;
          send_op(OP_ADD, h, 16'($urandom));
        end else if (pick < add_w + erase_w) begin
          case ($urandom_range(0, 9))
            0, 1:    h = hash_pool[$urandom_range(0, 127)];
            2:       h = $urandom;
            default: h = (ring_count > 0) ? ring_hash[idx] : $urandom;
          endcase
          send_op(OP_ERASE, h, 16'($urandom));
        end else if (pick < 95) begin
          case ($urandom_range(0, 9))
            0:       h = 32'h0000_0000;
            1:       h = 32'hFFFF_FFFF;
            2, 3:    h = ring_hash[idx] + 32'd1;
            4:       h = ring_hash[idx] - 32'd1;
            5, 6:    h = (ring_count > 0) ? ring_hash[idx] : $urandom;
            default: h = $urandom;
          endcase
          send_op(OP_LOOKUP, h, 16'($urandom));
        end else begin
          send_op(OP_SPARE, $urandom, 16'($urandom));
        end
      end
      if (phase == 3) wait_for_drain();
    end
    burst_mode = 1'b0;
  endtask

  // reset, tests in turn, then the verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_for_drain();
    test_full_ring();
    test_random_ops();
    wait_for_drain();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("ops: %0d add, %0d erase, %0d lookup, %0d spare; %0d lookups wrapped",
             op_seen[OP_ADD], op_seen[OP_ERASE], op_seen[OP_LOOKUP], op_seen[OP_SPARE],
             wrap_lookups);
    $display("status: %0d ok, %0d duplicate, %0d full, %0d not found, %0d empty",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
             status_seen[ST_MISSING], status_seen[ST_EMPTY]);
    if (error_count == 0) begin
      $display("consistent_hash_ring regression: pass");
    end else begin
      $display("consistent_hash_ring regression: fail");
    end
    $finish;
  end

endmodule
